// File: rtl/pesp_pkg.sv
// shared types and constants of the pcl escape sequence parser
package pesp_pkg;

    // default magnitude width of a parsed number
    localparam int MAG_WIDTH_DEF = 24;

    // field widths of a result word
    localparam int KIND_W  = 3;
    localparam int VALUE_W = 25;
    localparam int TDATA_W = 32;

    // control bytes
    localparam logic [7:0] ESC_BYTE = 8'h1B;
    localparam logic [7:0] FF_BYTE  = 8'h0C;

    // job end marker value of the percent-X sequence
    localparam int UEL_MAG = 12345;

    // event codes
    typedef enum logic [KIND_W-1:0] {
        EV_FF       = 3'd0,
        EV_RESET    = 3'd1,
        EV_DUPLEX   = 3'd2,
        EV_COPIES   = 3'd3,
        EV_HPGL_IN  = 3'd4,
        EV_HPGL_OUT = 3'd5,
        EV_EOJ      = 3'd6,
        EV_BAD      = 3'd7
    } ev_kind_t;

    // one event produced by the parser for the current byte
    typedef struct packed {
        logic               hit;
        ev_kind_t           kind;
        logic [VALUE_W-1:0] value;
    } evt_t;

endpackage

// File: rtl/pesp_parser.sv
// escape syntax state machine: one byte per cycle while item_valid is high, event for that byte
module pesp_parser #(
    parameter int MAG_WIDTH = pesp_pkg::MAG_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic [7:0]        item_byte,
    output pesp_pkg::evt_t    evt
);
    import pesp_pkg::*;

    localparam int PROD_W = MAG_WIDTH + 4;
    localparam int EXT_W  = MAG_WIDTH + VALUE_W;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_ESC    = 4'd1,
        PH_PREFIX = 4'd2,
        PH_GSTART = 4'd3,
        PH_GINT   = 4'd4,
        PH_GFRAC  = 4'd5,
        PH_PINT   = 4'd6,
        PH_PFRAC  = 4'd7
    } phase_t;

    phase_t                 phase_reg,  phase_next;
    logic [7:0]             prefix_reg, prefix_next;
    logic [7:0]             group_reg,  group_next;
    logic [MAG_WIDTH-1:0]   mag_reg,    mag_next;
    logic                   neg_reg,    neg_next;
    logic                   hpgl_reg,   hpgl_next;
    logic [MAG_WIDTH-1:0]   skip_reg,   skip_next;
    logic                   ended_reg,  ended_next;

    // byte classes
    logic is_digit, is_sign, is_dot, is_lower, is_upper, is_prefix, is_twochar;
    assign is_digit   = (item_byte >= 8'h30) && (item_byte <= 8'h39);
    assign is_sign    = (item_byte == "+") || (item_byte == "-");
    assign is_dot     = (item_byte == ".");
    assign is_lower   = (item_byte >= 8'h60) && (item_byte <= 8'h7E);
    assign is_upper   = (item_byte >= 8'h40) && (item_byte <= 8'h5E);
    assign is_prefix  = (item_byte >= 8'h21) && (item_byte <= 8'h2F);
    assign is_twochar = (item_byte >= 8'h30) && (item_byte <= 8'h7E);

    // decimal accumulate with saturation: mag*10 + digit
    logic [PROD_W-1:0]    prod;
    logic [MAG_WIDTH-1:0] mag_digit;
    assign prod = ({4'b0, mag_reg} << 3) + ({4'b0, mag_reg} << 1)
                + {{(PROD_W-4){1'b0}}, item_byte[3:0]};
    assign mag_digit = (prod[PROD_W-1:MAG_WIDTH] != 4'b0) ? {MAG_WIDTH{1'b1}}
                                                           : prod[MAG_WIDTH-1:0];

    // signed value of the number, low bits of two's complement
    logic [EXT_W-1:0]   mag_ext;
    logic [VALUE_W-1:0] signed_val;
    assign mag_ext    = {{VALUE_W{1'b0}}, mag_reg};
    assign signed_val = neg_reg ? VALUE_W'(-mag_ext) : mag_ext[VALUE_W-1:0];

    // command decode on prefix, group and terminator with the case bit cleared
    logic [7:0] term;
    logic       cmd_binary, cmd_duplex, cmd_copies, duplex_ok, uel_hit;
    assign term = {item_byte[7:6], 1'b0, item_byte[4:0]};

    always_comb
    begin
        cmd_binary = 1'b0;
        if (term == "W")
        begin
            cmd_binary = ((prefix_reg == "&") && (group_reg == "b"))
                      || ((prefix_reg == "&") && (group_reg == "n"))
                      || ((prefix_reg == "(") && (group_reg == "f"))
                      || ((prefix_reg == ")") && (group_reg == "s"))
                      || ((prefix_reg == "(") && (group_reg == "s"))
                      || ((prefix_reg == "*") && (group_reg == "c"))
                      || ((prefix_reg == "*") && (group_reg == "b"))
                      || ((prefix_reg == "*") && (group_reg == "v"))
                      || ((prefix_reg == "*") && (group_reg == "m"))
                      || ((prefix_reg == "*") && (group_reg == "l"))
                      || ((prefix_reg == "*") && (group_reg == "i"));
        end
        else if (term == "X")
        begin
            cmd_binary = (prefix_reg == "&") && (group_reg == "p");
        end
        else if (term == "V")
        begin
            cmd_binary = (prefix_reg == "*") && (group_reg == "b");
        end
    end

    assign cmd_duplex = (prefix_reg == "&") && (group_reg == "l") && (term == "S");
    assign cmd_copies = (prefix_reg == "&") && (group_reg == "l") && (term == "X");
    assign duplex_ok  = (mag_reg <= MAG_WIDTH'(2)) && (!neg_reg || (mag_reg == '0));
    assign uel_hit    = neg_reg && (mag_reg == MAG_WIDTH'(UEL_MAG));

    // next state and event for the byte at the input
    always_comb
    begin
        phase_next  = phase_reg;
        prefix_next = prefix_reg;
        group_next  = group_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        hpgl_next   = hpgl_reg;
        skip_next   = skip_reg;
        ended_next  = ended_reg;
        evt.hit     = 1'b0;
        evt.kind    = EV_FF;
        evt.value   = '0;

        if (ended_reg)
        begin
            // everything after end of job is dropped
        end
        else if (skip_reg != '0)
        begin
            skip_next = skip_reg - 1'b1;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (item_byte == ESC_BYTE)
                    begin
                        phase_next = PH_ESC;
                    end
                    else if ((item_byte == FF_BYTE) && !hpgl_reg)
                    begin
                        evt.hit  = 1'b1;
                        evt.kind = EV_FF;
                    end
                end
                PH_ESC:
                begin
                    if (is_prefix)
                    begin
                        prefix_next = item_byte;
                        phase_next  = PH_PREFIX;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        if (is_twochar)
                        begin
                            if (item_byte == "E")
                            begin
                                evt.hit  = 1'b1;
                                evt.kind = EV_RESET;
                            end
                        end
                        else
                        begin
                            evt.hit   = 1'b1;
                            evt.kind  = EV_BAD;
                            evt.value = {{(VALUE_W-8){1'b0}}, item_byte};
                        end
                    end
                end
                PH_PREFIX:
                begin
                    mag_next = '0;
                    neg_next = 1'b0;
                    if (is_lower)
                    begin
                        group_next = item_byte;
                        phase_next = PH_GSTART;
                    end
                    else if ((prefix_reg == "%") && is_sign)
                    begin
                        neg_next   = (item_byte == "-");
                        phase_next = PH_PINT;
                    end
                    else if ((prefix_reg == "%") && is_digit)
                    begin
                        mag_next   = {{(MAG_WIDTH-4){1'b0}}, item_byte[3:0]};
                        phase_next = PH_PINT;
                    end
                    else if ((prefix_reg == "%") && is_dot)
                    begin
                        phase_next = PH_PFRAC;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        evt.hit    = 1'b1;
                        evt.kind   = EV_BAD;
                        evt.value  = {{(VALUE_W-8){1'b0}}, item_byte};
                    end
                end
                PH_GSTART, PH_GINT, PH_GFRAC:
                begin
                    if ((phase_reg == PH_GSTART) && is_sign)
                    begin
                        neg_next   = (item_byte == "-");
                        phase_next = PH_GINT;
                    end
                    else if (is_digit)
                    begin
                        if (phase_reg != PH_GFRAC)
                        begin
                            mag_next   = mag_digit;
                            phase_next = PH_GINT;
                        end
                    end
                    else if (is_dot && (phase_reg != PH_GFRAC))
                    begin
                        phase_next = PH_GFRAC;
                    end
                    else if (is_upper || is_lower)
                    begin
                        // group terminator or lowercase continuation
                        phase_next = is_lower ? PH_GSTART : PH_IDLE;
                        if (is_lower)
                        begin
                            mag_next = '0;
                            neg_next = 1'b0;
                        end
                        if (cmd_binary)
                        begin
                            if (!neg_reg && (mag_reg != '0))
                            begin
                                skip_next = mag_reg;
                            end
                        end
                        else if (cmd_duplex)
                        begin
                            if (duplex_ok)
                            begin
                                evt.hit   = 1'b1;
                                evt.kind  = EV_DUPLEX;
                                evt.value = {{(VALUE_W-2){1'b0}}, mag_reg[1:0]};
                            end
                        end
                        else if (cmd_copies)
                        begin
                            evt.hit   = 1'b1;
                            evt.kind  = EV_COPIES;
                            evt.value = signed_val;
                        end
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        evt.hit    = 1'b1;
                        evt.kind   = EV_BAD;
                        evt.value  = {{(VALUE_W-8){1'b0}}, item_byte};
                    end
                end
                PH_PINT, PH_PFRAC:
                begin
                    if (is_digit)
                    begin
                        if (phase_reg == PH_PINT)
                        begin
                            mag_next = mag_digit;
                        end
                    end
                    else if (is_dot && (phase_reg == PH_PINT))
                    begin
                        phase_next = PH_PFRAC;
                    end
                    else
                    begin
                        // percent sequence terminator
                        phase_next = PH_IDLE;
                        if (item_byte == "B")
                        begin
                            hpgl_next = 1'b1;
                            evt.hit   = 1'b1;
                            evt.kind  = EV_HPGL_IN;
                        end
                        else if (item_byte == "A")
                        begin
                            hpgl_next = 1'b0;
                            evt.hit   = 1'b1;
                            evt.kind  = EV_HPGL_OUT;
                        end
                        else if ((item_byte == "X") && uel_hit)
                        begin
                            ended_next = 1'b1;
                            evt.hit    = 1'b1;
                            evt.kind   = EV_EOJ;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // parser state, updated once per consumed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            prefix_reg <= '0;
            group_reg  <= '0;
            mag_reg    <= '0;
            neg_reg    <= 1'b0;
            hpgl_reg   <= 1'b0;
            skip_reg   <= '0;
            ended_reg  <= 1'b0;
        end
        else if (item_valid)
        begin
            phase_reg  <= phase_next;
            prefix_reg <= prefix_next;
            group_reg  <= group_next;
            mag_reg    <= mag_next;
            neg_reg    <= neg_next;
            hpgl_reg   <= hpgl_next;
            skip_reg   <= skip_next;
            ended_reg  <= ended_next;
        end
    end

endmodule

// File: rtl/pcl_escape_sequence_parser_core.sv
// pcl escape sequence parser: byte stream in, event words out
// a byte accepted at the input is held in the input register, its event word in the output register
// throughput: one byte per cycle while the input register does not stall
// the input register stalls only while an event waits in a full output register
// reset clears the parser to text mode in pcl, empties both registers
// after end of job all bytes are consumed silently until the next reset
module pcl_escape_sequence_parser_core #(
    parameter int MAG_WIDTH = pesp_pkg::MAG_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] data_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [pesp_pkg::TDATA_W-1:0] m_tdata,   // [24:0] event_value, rest zero
    output logic [pesp_pkg::KIND_W-1:0]  m_tuser    // [2:0] event_kind
);
    import pesp_pkg::*;

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               out_valid_reg;
    logic [KIND_W-1:0]  out_kind_reg;
    logic [VALUE_W-1:0] out_value_reg;
    evt_t               evt;
    logic               out_free;
    logic               advance;

    // byte moves into the parser unless its event has nowhere to go
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!evt.hit || out_free);
    assign s_tready = !in_valid_reg || advance;

    pesp_parser #(
        .MAG_WIDTH (MAG_WIDTH)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (advance),
        .item_byte  (in_byte_reg),
        .evt        (evt)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && evt.hit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && evt.hit)
        begin
            out_kind_reg  <= evt.kind;
            out_value_reg <= evt.value;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {{(TDATA_W-VALUE_W){1'b0}}, out_value_reg};

endmodule

// File: rtl/pesp_checker.sv
// port-level checks of the parser core and their binding
module pesp_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [pesp_pkg::TDATA_W-1:0] m_tdata,
    input logic [pesp_pkg::KIND_W-1:0]  m_tuser
);
    import pesp_pkg::*;

    // a stalled event word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("event word changed while stalled");

    // padding above the value stays zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[TDATA_W-1:VALUE_W] == '0)
        else $error("padding bits set");

    // events without a value carry zero
    a_novalue: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == EV_FF || m_tuser == EV_RESET || m_tuser == EV_HPGL_IN
                     || m_tuser == EV_HPGL_OUT || m_tuser == EV_EOJ)
        |-> m_tdata[VALUE_W-1:0] == '0)
        else $error("nonzero value on a valueless event");

    // duplex mode is 0 to 2
    a_duplex: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == EV_DUPLEX |-> m_tdata[VALUE_W-1:0] <= VALUE_W'(2))
        else $error("duplex mode out of range");

    // unexpected byte report holds a byte
    a_bad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == EV_BAD |-> m_tdata[VALUE_W-1:8] == '0)
        else $error("unexpected byte report wider than a byte");

endmodule

bind pcl_escape_sequence_parser_core pesp_checker u_pesp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
